/* sv/v4n_pkg.sv */
// Constants and pipeline stage types for the four-component vector normalizer.
// Used by vec4_normalize; depends on nothing else.
package v4n_pkg;

  localparam int NC         = 4;   // components per vector
  localparam int CW         = 16;  // component width, Q3.12
  localparam int SQW        = 31;  // square of one magnitude, up to 2^30
  localparam int SW         = 33;  // sum of squares, up to 2^32
  localparam int QW         = 31;  // quotient a^2 * 2^30 / S, up to 2^30
  localparam int DIV_STEPS  = QW;  // one quotient bit per stage
  localparam int MAGW       = 17;  // magnitude root, up to 2^16
  localparam int MRW        = 19;  // magnitude root remainder
  localparam int MAG_STEPS  = MAGW;
  localparam int RTW        = 16;  // root of the quotient, up to 2^15
  localparam int RRW        = 18;  // remainder of the quotient root
  localparam int ROOT_STEPS = RTW;
  localparam int UW         = 16;  // unit component width, Q1.14

  // Input register, squares, sum, divider, root, output register.
  localparam int PIPE_DEPTH = 3 + DIV_STEPS + ROOT_STEPS + 1;

  typedef logic [NC-1:0][CW-1:0]  comp_vec_t;
  typedef logic [NC-1:0][SQW-1:0] sq_vec_t;

  typedef struct packed {
    logic [NC-1:0]          neg;
    logic                   zero;
    logic [SW-1:0]          s;
    logic [NC-1:0]          lsb;
    logic [NC-1:0][SW-1:0]  rem;
    logic [NC-1:0][QW-1:0]  quo;
    logic [MAGW-1:0]        mroot;
    logic [MRW-1:0]         mrem;
  } div_stage_t;

  typedef struct packed {
    logic [NC-1:0]          neg;
    logic                   zero;
    logic [MAGW-1:0]        mroot;
    logic [MRW-1:0]         mrem;
    logic [NC-1:0][QW-1:0]  rad;
    logic [NC-1:0][RRW-1:0] rem;
    logic [NC-1:0][RTW-1:0] root;
  } root_stage_t;

endpackage

/* sv/vec4_normalize.sv */
// Four-component vector normalizer: magnitude and unit vector, fully pipelined.
// Depends on v4n_pkg for widths, step counts and stage record types.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------------
//   vector   vec_valid, vec_stall   comp_x, comp_y, comp_z, comp_w (signed Q3.12)
//   result   res_valid, res_stall   unit_x..unit_w (Q1.14), magnitude, zero_vector
//
// A new vector can be transferred in every cycle while vec_stall is low. Its result
// is loaded into the output register through the input register, squaring, summing,
// 31 divider stages (one quotient bit each), 16 root stages and the output register.
// Synchronous reset clears only the pipeline valid bits; data registers are not reset.
// While a finished result waits in the output register with res_stall high, every
// stage holds and vec_stall is raised.
module vec4_normalize (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            vec_valid,
  output logic                            vec_stall,
  input  logic signed [v4n_pkg::CW-1:0]   comp_x,
  input  logic signed [v4n_pkg::CW-1:0]   comp_y,
  input  logic signed [v4n_pkg::CW-1:0]   comp_z,
  input  logic signed [v4n_pkg::CW-1:0]   comp_w,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic signed [v4n_pkg::UW-1:0]   unit_x,
  output logic signed [v4n_pkg::UW-1:0]   unit_y,
  output logic signed [v4n_pkg::UW-1:0]   unit_z,
  output logic signed [v4n_pkg::UW-1:0]   unit_w,
  output logic        [v4n_pkg::MAGW-1:0] magnitude,
  output logic                            zero_vector
);
  import v4n_pkg::*;

  // The algorithm. With S the sum of squares and a the size of one component,
  // the rounded unit value is floor(x + 1/2) where x = a * 2^14 / sqrt(S).
  // That equals (m + 1) >> 1 with m = floor(2x) = isqrt(floor(a^2 * 2^30 / S)),
  // so each component needs one exact long division and one integer square
  // root, and no step ever handles an irrational value. The magnitude is
  // isqrt(S), rounded up when the root remainder exceeds the root.

  logic en;
  logic [PIPE_DEPTH-1:0] vld;

  // The whole pipeline advances unless the output register is full and held.
  assign en        = !vld[PIPE_DEPTH-1] || !res_stall;
  assign vec_stall = !en;
  assign res_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], vec_valid};
    end
  end

  // Input register: split each component into sign and size.
  comp_vec_t     comp_in;
  comp_vec_t     p0_abs;
  logic [NC-1:0] p0_neg;

  assign comp_in = {comp_w, comp_z, comp_y, comp_x};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        p0_neg[c] <= comp_in[c][CW-1];
        p0_abs[c] <= comp_in[c][CW-1] ? (~comp_in[c] + CW'(1)) : comp_in[c];
      end
    end
  end

  // Squares of the sizes.
  sq_vec_t       p1_sq;
  logic [NC-1:0] p1_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_neg <= p0_neg;
      for (int c = 0; c < NC; c++) begin
        p1_sq[c] <= SQW'(p0_abs[c] * p0_abs[c]);
      end
    end
  end

  // Sum of squares.
  sq_vec_t       p2_sq;
  logic [NC-1:0] p2_neg;
  logic [SW-1:0] p2_s;
  logic          p2_zero;
  logic [SW-1:0] sum_next;

  assign sum_next = SW'(p1_sq[0]) + SW'(p1_sq[1]) + SW'(p1_sq[2]) + SW'(p1_sq[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sq   <= p1_sq;
      p2_neg  <= p1_neg;
      p2_s    <= sum_next;
      p2_zero <= (sum_next == '0);
    end
  end

  // Divider seed. The quotient is below 2^31, so the remainder can start from
  // a^2 / 2, with the low bit of a^2 brought in by the first stage.
  div_stage_t div_seed;
  div_stage_t div_q [DIV_STEPS];

  always_comb begin
    div_seed       = '0;
    div_seed.neg   = p2_neg;
    div_seed.zero  = p2_zero;
    div_seed.s     = p2_s;
    for (int c = 0; c < NC; c++) begin
      div_seed.rem[c] = SW'(p2_sq[c] >> 1);
      div_seed.lsb[c] = p2_sq[c][0];
    end
  end

  // Each divider stage yields one quotient bit for all four components. The
  // first MAG_STEPS stages also run one step of the magnitude square root.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_stage_t      prv;
    div_stage_t      nxt;
    logic [MAGW-1:0] mroot_nx;
    logic [MRW-1:0]  mrem_nx;

    if (k == 0) begin : g_first
      assign prv = div_seed;
    end else begin : g_rest
      assign prv = div_q[k-1];
    end

    if (k < MAG_STEPS) begin : g_mag
      localparam int PI = MAG_STEPS - 1 - k;
      always_comb begin
        logic [SW:0]    sp;
        logic [MRW+1:0] mr;
        logic [MRW+1:0] tr;
        logic           ge;
        sp       = {1'b0, prv.s};
        mr       = {prv.mrem, sp[2*PI +: 2]};
        tr       = {{(MRW-MAGW){1'b0}}, prv.mroot, 2'b01};
        ge       = (mr >= tr);
        mrem_nx  = ge ? MRW'(mr - tr) : MRW'(mr);
        mroot_nx = {prv.mroot[MAGW-2:0], ge};
      end
    end else begin : g_mag_hold
      assign mroot_nx = prv.mroot;
      assign mrem_nx  = prv.mrem;
    end

    always_comb begin
      logic [SW:0] t;
      logic [SW:0] dv;
      logic        ge;
      nxt       = prv;
      nxt.lsb   = '0;
      nxt.mroot = mroot_nx;
      nxt.mrem  = mrem_nx;
      dv        = {1'b0, prv.s};
      for (int c = 0; c < NC; c++) begin
        t          = {prv.rem[c], prv.lsb[c]};
        ge         = (t >= dv);
        nxt.rem[c] = ge ? SW'(t - dv) : SW'(t);
        nxt.quo[c] = {prv.quo[c][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[k] <= nxt;
      end
    end
  end

  // Square root of each quotient, two radicand bits per stage.
  root_stage_t root_seed;
  root_stage_t root_q [ROOT_STEPS];

  always_comb begin
    root_seed       = '0;
    root_seed.neg   = div_q[DIV_STEPS-1].neg;
    root_seed.zero  = div_q[DIV_STEPS-1].zero;
    root_seed.mroot = div_q[DIV_STEPS-1].mroot;
    root_seed.mrem  = div_q[DIV_STEPS-1].mrem;
    root_seed.rad   = div_q[DIV_STEPS-1].quo;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam int PI = ROOT_STEPS - 1 - k;
    root_stage_t prv;
    root_stage_t nxt;

    if (k == 0) begin : g_first
      assign prv = root_seed;
    end else begin : g_rest
      assign prv = root_q[k-1];
    end

    always_comb begin
      logic [QW:0]    rp;
      logic [RRW+1:0] mr;
      logic [RRW+1:0] tr;
      logic           ge;
      nxt = prv;
      for (int c = 0; c < NC; c++) begin
        rp          = {1'b0, prv.rad[c]};
        mr          = {prv.rem[c], rp[2*PI +: 2]};
        tr          = {{(RRW-RTW){1'b0}}, prv.root[c], 2'b01};
        ge          = (mr >= tr);
        nxt.rem[c]  = ge ? RRW'(mr - tr) : RRW'(mr);
        nxt.root[c] = {prv.root[c][RTW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= nxt;
      end
    end
  end

  // Final rounding, sign and the zero vector case.
  root_stage_t                fin;
  logic [NC-1:0][UW-1:0]      unit_next;
  logic [MAGW-1:0]            mag_next;

  assign fin = root_q[ROOT_STEPS-1];

  always_comb begin
    logic [RTW:0]  q1;
    logic [UW-1:0] q;
    for (int c = 0; c < NC; c++) begin
      q1 = {1'b0, fin.root[c]} + (RTW+1)'(1);
      q  = UW'(q1[RTW:1]);
      if (fin.zero) begin
        unit_next[c] = '0;
      end else begin
        unit_next[c] = fin.neg[c] ? (~q + UW'(1)) : q;
      end
    end
    if (fin.zero) begin
      mag_next = '0;
    end else if (fin.mrem > MRW'(fin.mroot)) begin
      mag_next = fin.mroot + MAGW'(1);
    end else begin
      mag_next = fin.mroot;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x      <= unit_next[0];
      unit_y      <= unit_next[1];
      unit_z      <= unit_next[2];
      unit_w      <= unit_next[3];
      magnitude   <= mag_next;
      zero_vector <= fin.zero;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for vec4_normalize, the four-component vector normalizer.
// Holds its own integer predictor and relies only on v4n_pkg and the block's ports.
// A directed table comes first, then about 1600 random vectors under changing flow control.
module tb;
  import v4n_pkg::*;

  // Number of random vectors in each flow-control phase.
  localparam int PHASE_ITEMS [3] = '{540, 540, 520};
  // The run is ended as failed if it is still going after this many cycles.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the long receiver hold-off; well past the pipeline depth.
  localparam int LONG_HOLD = 300;

  // One normalized result, laid out as the block's result fields.
  typedef struct packed {
    logic [NC-1:0][UW-1:0] unit;      // index 0 is x, 3 is w
    logic [MAGW-1:0]       mag;
    logic                  zero;
  } norm_t;

  // One directed row: a vector and, where it is obvious, its answer typed in.
  typedef struct packed {
    comp_vec_t vec;
    logic      typed;
    norm_t     want;
  } stim_row_t;

  // What the sender knows about an offered vector beyond its components.
  typedef struct packed {
    logic  typed;
    norm_t want;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vec_valid = 1'b0;
  logic vec_stall;
  logic signed [CW-1:0] comp_x = '0;
  logic signed [CW-1:0] comp_y = '0;
  logic signed [CW-1:0] comp_z = '0;
  logic signed [CW-1:0] comp_w = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [UW-1:0] unit_x;
  logic signed [UW-1:0] unit_y;
  logic signed [UW-1:0] unit_z;
  logic signed [UW-1:0] unit_w;
  logic [MAGW-1:0] magnitude;
  logic zero_vector;

  // Flow-control knobs, in percent of cycles; changed by the main sequence.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Long hold-off request and the receiver's own countdown for it.
  logic hold_go = 1'b0;
  logic hold_started = 1'b0;
  int hold_left = 0;

  int cycle_count = 0;
  int errors = 0;

  answer_t known_answers[$];     // one entry per offered vector, in order
  norm_t awaited_results[$];     // results owed by the block, oldest first
  stim_row_t dir_rows[$];

  vec4_normalize dut (
    .clk         (clk),
    .rst         (rst),
    .vec_valid   (vec_valid),
    .vec_stall   (vec_stall),
    .comp_x      (comp_x),
    .comp_y      (comp_y),
    .comp_z      (comp_z),
    .comp_w      (comp_w),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .unit_x      (unit_x),
    .unit_y      (unit_y),
    .unit_z      (unit_z),
    .unit_w      (unit_w),
    .magnitude   (magnitude),
    .zero_vector (zero_vector)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicts the normalized vector with exact integer arithmetic. The sum of
  // squares needs 33 bits and the rounding tests below need up to 62 bits, so
  // everything is carried in 64-bit unsigned values.
  function automatic norm_t normalize_vec(input comp_vec_t c);
    norm_t r;
    longint cv;
    longint unsigned absv [NC];
    longint unsigned s, root, t, q, o, num, rhs;
    r = '0;
    s = 0;
    for (int i = 0; i < NC; i++) begin
      cv = $signed(c[i]);
      absv[i] = (cv < 0) ? longint'(-cv) : longint'(cv);
      s += absv[i] * absv[i];
    end
    if (s == 0) begin
      // An all-zero vector has no direction: flag it and return zeros.
      r.zero = 1'b1;
      return r;
    end
    // Integer square root, one result bit at a time, then round to nearest.
    // The midpoint r + 1/2 is never hit exactly, so s > r*r + r decides it.
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= s)
        root = t;
    end
    r.mag = (s > root * root + root) ? MAGW'(root + 1) : MAGW'(root);
    // Each unit component is the largest q in 0..16384 whose lower rounding
    // boundary (q - 1/2) still lies at or below |c| * 2^14 / sqrt(s). Squaring
    // both sides keeps the test exact; ties therefore round away from zero.
    for (int i = 0; i < NC; i++) begin
      num = absv[i] << 14;
      rhs = 4 * num * num;
      q = 0;
      for (int b = 14; b >= 0; b--) begin
        t = q | (64'd1 << b);
        if (t <= 16384) begin
          o = 2 * t - 1;
          if (o * o * s <= rhs)
            q = t;
        end
      end
      r.unit[i] = ($signed(c[i]) < 0) ? UW'(-q) : UW'(q);
    end
    return r;
  endfunction

  // Adds one directed row to the table. Answer fields are ignored when typed is 0.
  function automatic void add_row(input int x, input int y, input int z, input int w,
                                  input bit typed, input int ux, input int uy,
                                  input int uz, input int uw, input int mag,
                                  input bit zero);
    stim_row_t r;
    r.vec = {CW'(w), CW'(z), CW'(y), CW'(x)};
    r.typed = typed;
    r.want.unit = {UW'(uw), UW'(uz), UW'(uy), UW'(ux)};
    r.want.mag = MAGW'(mag);
    r.want.zero = zero;
    dir_rows.push_back(r);
  endfunction

  // Random vectors of several shapes. Plain uniform components exercise every
  // bit; the other shapes reach the corners that uniform values almost never
  // hit: tiny magnitudes where rounding dominates, one dominant axis where the
  // other components round to zero, full-scale extremes and zero vectors.
  function automatic comp_vec_t random_vec();
    comp_vec_t v;
    int axis;
    v = '0;
    case ($urandom_range(9, 0)) inside
      [0:4]: begin
        for (int i = 0; i < NC; i++)
          v[i] = CW'($urandom);
      end
      [5:6]: begin
        for (int i = 0; i < NC; i++)
          v[i] = CW'(int'($urandom_range(15, 0)) - 8);
      end
      7: begin
        axis = $urandom_range(NC - 1, 0);
        for (int i = 0; i < NC; i++)
          v[i] = (i == axis) ? CW'($urandom) : CW'(int'($urandom_range(7, 0)) - 4);
      end
      8: begin
        for (int i = 0; i < NC; i++) begin
          case ($urandom_range(4, 0))
            0: v[i] = 16'sh8000;
            1: v[i] = 16'sh7fff;
            2: v[i] = 16'sh0000;
            3: v[i] = 16'shffff;
            default: v[i] = 16'sh0001;
          endcase
        end
      end
      default: begin
        // Half of these are the zero vector, the rest have a single axis set.
        if ($urandom_range(1, 0) == 1)
          v[$urandom_range(NC - 1, 0)] = CW'($urandom);
      end
    endcase
    return v;
  endfunction

  // Offers one vector and returns once it has been transferred. The sender may
  // idle first; once valid is raised, the payload holds until the transfer.
  // The caller is always just past a rising edge.
  task automatic send_vec(input comp_vec_t v, input logic typed, input norm_t want);
    answer_t a;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      vec_valid <= 1'b0;
      @(posedge clk);
    end
    a.typed = typed;
    a.want = want;
    known_answers.push_back(a);
    vec_valid <= 1'b1;
    comp_x <= v[0];
    comp_y <= v[1];
    comp_z <= v[2];
    comp_w <= v[3];
    @(posedge clk);
    while (vec_stall)
      @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic signed [MAGW:0] want,
                             input logic signed [MAGW:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // Receiver. Stalls at random at the current rate, except during the one
  // long hold-off, when it keeps res_stall high throughout so that the pipeline
  // fills and the block pushes back on its input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_started) begin
      res_stall <= 1'b1;
      hold_started <= 1'b1;
      hold_left <= LONG_HOLD - 1;
    end else begin
      res_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Monitor and scoreboard. Both channels are sampled at the rising edge, so
  // every value seen here is the one that was present before the edge.
  always @(posedge clk) begin
    answer_t a;
    norm_t want;
    if (!rst && vec_valid && !vec_stall) begin
      // An input transfer: queue the answer that the block now owes.
      a = known_answers.pop_front();
      if (a.typed)
        want = a.want;
      else
        want = normalize_vec({comp_w, comp_z, comp_y, comp_x});
      awaited_results.push_back(want);
    end
    if (!rst && res_valid && !res_stall) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no vector outstanding, magnitude %0d",
                 $time, magnitude);
      end else begin
        want = awaited_results.pop_front();
        check_field("unit_x", (MAGW+1)'($signed(want.unit[0])), (MAGW+1)'(unit_x));
        check_field("unit_y", (MAGW+1)'($signed(want.unit[1])), (MAGW+1)'(unit_y));
        check_field("unit_z", (MAGW+1)'($signed(want.unit[2])), (MAGW+1)'(unit_z));
        check_field("unit_w", (MAGW+1)'($signed(want.unit[3])), (MAGW+1)'(unit_w));
        check_field("magnitude", (MAGW+1)'(want.mag), (MAGW+1)'(magnitude));
        check_field("zero_vector", (MAGW+1)'(want.zero), (MAGW+1)'(zero_vector));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    norm_t none;
    none = '0;

    // Directed table. Answers are typed in where they follow at once: the
    // zero vector, full scale, single-axis extremes and vectors of equal
    // magnitude components. The remaining rows go to the predictor.
    //      x       y       z       w       typ ux      uy      uz      uw      mag    zv
    add_row(0,      0,      0,      0,      1, 0,      0,      0,      0,      0,     1);
    add_row(-32768, -32768, -32768, -32768, 1, -8192,  -8192,  -8192,  -8192,  65536, 0);
    add_row(32767,  32767,  32767,  32767,  1, 8192,   8192,   8192,   8192,   65534, 0);
    add_row(32767,  0,      0,      0,      1, 16384,  0,      0,      0,      32767, 0);
    add_row(-32768, 0,      0,      0,      1, -16384, 0,      0,      0,      32768, 0);
    add_row(0,      32767,  0,      0,      1, 0,      16384,  0,      0,      32767, 0);
    add_row(0,      0,      -32768, 0,      1, 0,      0,      -16384, 0,      32768, 0);
    add_row(0,      0,      0,      1,      1, 0,      0,      0,      16384,  1,     0);
    add_row(0,      -1,     0,      0,      1, 0,      -16384, 0,      0,      1,     0);
    add_row(0,      0,      0,      -1,     1, 0,      0,      0,      -16384, 1,     0);
    add_row(4096,   4096,   4096,   4096,   1, 8192,   8192,   8192,   8192,   8192,  0);
    add_row(1,      1,      1,      1,      1, 8192,   8192,   8192,   8192,   2,     0);
    add_row(-1,     1,      -1,     1,      1, -8192,  8192,   -8192,  8192,   2,     0);
    add_row(3,      4,      0,      0,      0, 0,      0,      0,      0,      0,     0);
    add_row(1,      1,      0,      0,      0, 0,      0,      0,      0,      0,     0);
    add_row(1,      1,      1,      0,      0, 0,      0,      0,      0,      0,     0);
    add_row(32767,  -32768, 0,      0,      0, 0,      0,      0,      0,      0,     0);
    add_row(-32768, 32767,  -32768, 32767,  0, 0,      0,      0,      0,      0,     0);
    add_row(1,      0,      0,      -32768, 0, 0,      0,      0,      0,      0,     0);
    add_row(12345,  -6789,  1000,   -2,     0, 0,      0,      0,      0,      0,     0);
    add_row(21845,  -21846, 21845,  -21846, 0, 0,      0,      0,      0,      0,     0);

    // Hold reset before the first transfer; the block only clears its valid bits.
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed rows and the first random phase run with the sender idle
    // about a quarter of the time and the receiver stalling most of the time.
    send_idle_pct = 24;
    recv_stall_pct <= 61;
    foreach (dir_rows[i])
      send_vec(dir_rows[i].vec, dir_rows[i].typed, dir_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        1: begin
          send_idle_pct = 61;
          recv_stall_pct <= 24;
        end
        2: begin
          // No idling at all. The long hold-off starts here while the sender
          // keeps offering, so the pipeline fills and vec_stall rises.
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          hold_go <= 1'b1;
        end
        default: ;
      endcase
      for (int n = 0; n < PHASE_ITEMS[phase]; n++)
        send_vec(random_vec(), 1'b0, none);
    end
    vec_valid <= 1'b0;

    // Drain: wait for every owed result, then keep sampling so that any stray
    // extra result is caught. The watchdog bounds it.
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
